// ===== src/disk_seek_scheduler_macros.svh =====
// assertion helpers
`ifndef DISK_SEEK_SCHEDULER_MACROS_SVH
`define DISK_SEEK_SCHEDULER_MACROS_SVH
`define DSS_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define DSS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== src/dss_pkg.sv =====
package dss_pkg;
    localparam int unsigned CYL_W = 16;
    localparam int unsigned SEEK_W = 22;
    localparam logic [SEEK_W-1:0] SEEK_MAX = '1;

    localparam logic [2:0] POL_FCFS  = 3'd0;
    localparam logic [2:0] POL_SSTF  = 3'd1;
    localparam logic [2:0] POL_SCAN  = 3'd2;
    localparam logic [2:0] POL_CSCAN = 3'd3;
    localparam logic [2:0] POL_LOOK  = 3'd4;
    localparam logic [2:0] POL_CLOOK = 3'd5;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_HEAD   = 2'd1;
    localparam logic [1:0] REG_SIZE   = 2'd2;
    localparam logic [1:0] REG_DOWN   = 2'd3;

    typedef struct packed {
        logic [CYL_W-1:0] cylinder;
        logic             last_request;
    } t_in;

    typedef struct packed {
        logic [CYL_W-1:0]  served_position;
        logic [SEEK_W-1:0] seek_total;
        logic              last_result;
    } t_out;

    typedef enum logic [2:0] {
        ST_LOAD, ST_EDGE, ST_INIT, ST_SCAN, ST_EMIT, ST_WAIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // store incoming request
        logic start;     // begin batch: clear served flags and seek, set edge stops and head
        logic scan_clr;  // reset search pass
        logic scan_step; // examine one entry
        logic emit;      // commit chosen candidate to output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done; // all entries examined
        logic found;     // a candidate exists
        logic none_left; // nothing remains after this emit
    } t_sts;
endpackage

// ===== src/dss_ctrl.sv =====
module dss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    input  logic          i_out_stall,
    input  dss_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output dss_pkg::t_cmd o_cmd
);
    import dss_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: if (i_in_valid && i_in_last) n_state = ST_EDGE;
            ST_EDGE: n_state = ST_INIT;
            ST_INIT: n_state = ST_SCAN;
            ST_SCAN: if (i_sts.scan_done) n_state = i_sts.found ? ST_EMIT : ST_LOAD;
            ST_EMIT: n_state = ST_WAIT;
            ST_WAIT: begin
                if (!i_out_stall) begin
                    n_state = i_sts.none_left ? ST_LOAD : ST_SCAN;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_stall = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_EDGE: o_cmd.start = 1'b1;
            ST_INIT: o_cmd.scan_clr = 1'b1;
            ST_SCAN: o_cmd.scan_step = 1'b1;
            ST_EMIT: o_cmd.emit = 1'b1;
            ST_WAIT: begin
                o_out_valid = 1'b1;
                o_cmd.scan_clr = !i_out_stall;
            end
            default: o_in_stall = 1'b1;
        endcase
    end
endmodule

// ===== src/dss_datapath.sv =====
module dss_datapath #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dss_pkg::t_in  i_in,
    input  logic [2:0]    i_policy,
    input  logic [15:0]   i_start_head,
    input  logic [16:0]   i_disk_size,
    input  logic          i_moving_down,
    input  dss_pkg::t_cmd i_cmd,
    output dss_pkg::t_sts o_sts,
    output dss_pkg::t_out o_out
);
    import dss_pkg::*;

    localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int SW = $clog2(MAX_REQUESTS + 3);

    logic [CYL_W-1:0] r_store [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] r_served;
    logic [CW-1:0] r_count;
    logic [CYL_W-1:0] r_head;
    logic [SEEK_W-1:0] r_seek;
    logic r_edge_lo, r_edge_hi;   // pending edge stops
    logic [SW-1:0] r_left;
    logic [CW-1:0] r_idx;
    logic r_phase2;               // second group of sweep
    logic r_found;
    logic [CYL_W-1:0] r_best;
    logic [CYL_W:0] r_bkey;
    logic [IW-1:0] r_bidx;
    logic r_bedge;                // best is an edge stop
    logic r_bedge_lo;
    logic [CYL_W-1:0] r_rd;
    logic r_rd_v;
    logic [IW-1:0] r_rd_idx;
    t_out r_out;

    logic [CYL_W-1:0] start_h, top;
    logic [16:0] size_c;
    logic is_sweep, circ, down, edge_hi_en, edge_lo_en;
    logic [CYL_W-1:0] hop;
    logic [SEEK_W:0] sum;

    assign start_h = i_start_head;
    assign size_c = (i_disk_size == 17'd0) ? 17'd1 :
                    (i_disk_size > 17'h10000) ? 17'h10000 : i_disk_size;
    assign top = CYL_W'(size_c - 17'd1);
    assign is_sweep = (i_policy >= POL_SCAN) && (i_policy <= POL_CLOOK);
    assign circ = (i_policy == POL_CSCAN) || (i_policy == POL_CLOOK);
    assign down = i_moving_down;
    assign edge_hi_en = (i_policy == POL_CSCAN) || ((i_policy == POL_SCAN) && !down);
    assign edge_lo_en = (i_policy == POL_CSCAN) || ((i_policy == POL_SCAN) && down);

    // group: 1 = low (<= start head), scanning direction per group
    // top edge stop always belongs to the high group
    function automatic logic [CYL_W:0] sweep_key(input logic [CYL_W-1:0] v,
                                                 input logic ph2, input logic dn,
                                                 input logic cc,
                                                 input logic [CYL_W-1:0] h,
                                                 input logic pin_hi);
        logic lo, want_lo, asc;
        lo = (v <= h) && !pin_hi;
        want_lo = dn ^ ph2;
        asc = want_lo ? (dn ? 1'b0 : cc) : (dn ? !cc : 1'b1);
        if (lo != want_lo) sweep_key = '1;
        else sweep_key = {1'b0, asc ? v : ~v};
    endfunction

    logic [CYL_W:0] key;
    logic cand_ok;
    always_comb begin
        key = '1;
        if (i_policy == POL_SSTF) key = {1'b0, (r_rd > r_head) ? r_rd - r_head : r_head - r_rd};
        else if (is_sweep) key = sweep_key(r_rd, r_phase2, down, circ, start_h, 1'b0);
        else key = {1'b0, CYL_W'(r_rd_idx)};
        cand_ok = r_rd_v && !r_served[r_rd_idx] && (key != '1);
    end

    logic group_retry;
    assign group_retry = !r_found && !cand_ok && !r_phase2 && is_sweep && r_left != '0;

    logic [CYL_W:0] ekey_hi, ekey_lo, ekey_hi2, ekey_lo2;
    assign ekey_hi = sweep_key(top, r_phase2, down, circ, start_h, 1'b1);
    assign ekey_lo = sweep_key('0, r_phase2, down, circ, start_h, 1'b0);
    assign ekey_hi2 = sweep_key(top, 1'b1, down, circ, start_h, 1'b1);
    assign ekey_lo2 = sweep_key('0, 1'b1, down, circ, start_h, 1'b0);

    assign hop = (r_best > r_head) ? r_best - r_head : r_head - r_best;
    assign sum = {1'b0, r_seek} + (SEEK_W+1)'(hop);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CW'(MAX_REQUESTS))) begin
            r_store[r_count[IW-1:0]] <= i_in.cylinder;
        end
        r_rd <= r_store[r_idx[IW-1:0]];
        r_rd_idx <= r_idx[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_served <= '0;
            r_head <= '0;
            r_seek <= '0;
            r_edge_lo <= 1'b0;
            r_edge_hi <= 1'b0;
            r_left <= '0;
            r_idx <= '0;
            r_phase2 <= 1'b0;
            r_found <= 1'b0;
            r_rd_v <= 1'b0;
        end else begin
            if (i_cmd.load && (r_count < CW'(MAX_REQUESTS))) r_count <= r_count + 1'b1;
            if (i_cmd.start) begin
                r_served <= '0;
                r_head <= start_h;
                r_seek <= '0;
                r_phase2 <= 1'b0;
                r_edge_hi <= is_sweep && edge_hi_en;
                r_edge_lo <= is_sweep && edge_lo_en;
                r_left <= SW'(r_count) + SW'(is_sweep && edge_hi_en)
                          + SW'(is_sweep && edge_lo_en);
            end
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
                r_found <= 1'b0;
                r_rd_v <= 1'b0;
                r_bkey <= '1;
                r_bedge <= 1'b0;
                if (r_edge_hi && ekey_hi != '1) begin
                    r_found <= 1'b1; r_bkey <= ekey_hi; r_best <= top;
                    r_bedge <= 1'b1; r_bedge_lo <= 1'b0;
                end else if (r_edge_lo && ekey_lo != '1) begin
                    r_found <= 1'b1; r_bkey <= ekey_lo; r_best <= '0;
                    r_bedge <= 1'b1; r_bedge_lo <= 1'b1;
                end
                // hi edge key ties with hi request only at top: edge sorts first, fine
            end
            if (i_cmd.scan_step) begin
                if (r_idx < r_count) r_idx <= r_idx + 1'b1;
                r_rd_v <= (r_idx < r_count);
                if (cand_ok && (!r_found || key < r_bkey)) begin
                    r_found <= 1'b1; r_bkey <= key; r_best <= r_rd;
                    r_bidx <= r_rd_idx; r_bedge <= 1'b0;
                end
                // nothing in this group: move to second group and rescan
                if ((r_idx >= r_count) && group_retry) begin
                    r_phase2 <= 1'b1;
                    r_idx <= '0;
                    r_rd_v <= 1'b0;
                    r_bedge <= 1'b0;
                    if (r_edge_hi && ekey_hi2 != '1) begin
                        r_found <= 1'b1; r_bkey <= ekey_hi2; r_best <= top;
                        r_bedge <= 1'b1; r_bedge_lo <= 1'b0;
                    end else if (r_edge_lo && ekey_lo2 != '1) begin
                        r_found <= 1'b1; r_bkey <= ekey_lo2; r_best <= '0;
                        r_bedge <= 1'b1; r_bedge_lo <= 1'b1;
                    end
                end
            end
            if (i_cmd.emit) begin
                if (r_bedge) begin
                    if (r_bedge_lo) r_edge_lo <= 1'b0;
                    else r_edge_hi <= 1'b0;
                end else begin
                    r_served[r_bidx] <= 1'b1;
                end
                r_head <= r_best;
                r_seek <= sum[SEEK_W] ? SEEK_MAX : sum[SEEK_W-1:0];
                r_left <= r_left - 1'b1;
                if (r_left == SW'(1)) r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.served_position <= r_best;
            r_out.seek_total <= sum[SEEK_W] ? SEEK_MAX : sum[SEEK_W-1:0];
            r_out.last_result <= (r_left == SW'(1));
        end
    end

    assign o_sts.scan_done = (r_idx >= r_count) && !group_retry;
    assign o_sts.found = r_found || cand_ok;
    assign o_sts.none_left = (r_left == '0);
    assign o_out = r_out;
endmodule

// ===== src/disk_seek_scheduler.sv =====
// Requests load one per cycle; input stalls while a batch is scheduled.
// With N stored requests, each result is found by a scan of the store through a
// registered read, then emitted and transferred; a sweep rescans once when it
// moves to its second group. Up to N+2 results a batch.
// Synchronous active-low reset: store empty, registers 0, 0, 65536, 0.
module disk_seek_scheduler #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dss_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output dss_pkg::t_out o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import dss_pkg::*;

    logic [2:0] r_policy;
    logic [15:0] r_start;
    logic [16:0] r_size;
    logic r_down;
    t_cmd cmd;
    t_sts sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= '0;
            r_start <= '0;
            r_size <= 17'h10000;
            r_down <= 1'b0;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            case (paddr[3:2])
                REG_POLICY: r_policy <= pwdata[2:0];
                REG_HEAD:   r_start <= pwdata[15:0];
                REG_SIZE:   r_size <= pwdata[16:0];
                REG_DOWN:   r_down <= pwdata[0];
                default:    r_down <= r_down;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_POLICY: prdata = {29'd0, r_policy};
            REG_HEAD:   prdata = {16'd0, r_start};
            REG_SIZE:   prdata = {15'd0, r_size};
            REG_DOWN:   prdata = {31'd0, r_down};
            default:    prdata = '0;
        endcase
    end

    dss_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_in_last(i_in.last_request), .i_out_stall(i_out_stall), .i_sts(sts),
        .o_in_stall(o_in_stall), .o_out_valid(o_out_valid), .o_cmd(cmd)
    );

    dss_datapath #(.MAX_REQUESTS(MAX_REQUESTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_policy(r_policy),
        .i_start_head(r_start), .i_disk_size(r_size), .i_moving_down(r_down),
        .i_cmd(cmd), .o_sts(sts), .o_out(o_out)
    );
endmodule

// ===== src/dss_checker.sv =====
`include "disk_seek_scheduler_macros.svh"
module dss_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input dss_pkg::t_out o_out
);
    `DSS_ASSERT_IMPL(a_excl, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `DSS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out))
    `DSS_ASSERT_NEXT(a_mono, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_out.last_result,
        !o_out_valid || o_out.seek_total >= $past(o_out.seek_total))
endmodule

bind disk_seek_scheduler dss_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out(o_out)
);

// ===== verif/disk_seek_scheduler_tb.sv =====
module disk_seek_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dss_pkg::*;

    localparam int MAXQ = 32;
    localparam int IDLE_LIMIT = 20000;

    class seek_scoreboard;
        logic [CYL_W-1:0] store[MAXQ];
        int unsigned cnt;
        logic [2:0] policy;
        logic [CYL_W-1:0] head0;
        logic [16:0] dsize;
        bit down;
        logic [CYL_W-1:0] head;
        logic [SEEK_W-1:0] seek;
        t_out pending[$];
        int errors;

        function new();
            cnt = 0; policy = POL_FCFS; head0 = 0; dsize = 17'd65536; down = 0;
            errors = 0;
        endfunction

        function void visit(logic [CYL_W-1:0] pos);
            int unsigned d;
            int unsigned s;
            t_out r;
            d = (pos > head) ? pos - head : head - pos;
            s = seek + d;
            seek = (s > SEEK_MAX) ? SEEK_MAX : s[SEEK_W-1:0];
            head = pos;
            r.served_position = pos;
            r.seek_total = seek;
            r.last_result = 1'b0;
            pending.push_back(r);
        endfunction

        function void schedule();
            logic [CYL_W-1:0] lo[$], hi[$];
            bit used[MAXQ];
            int best, nq, i;
            int unsigned bd, d, sz;
            bit circ;
            t_out r;
            nq = pending.size();
            head = head0;
            seek = 0;
            if (policy == POL_SSTF) begin
                foreach (used[k]) used[k] = 0;
                repeat (cnt) begin
                    best = -1; bd = 0;
                    for (i = 0; i < cnt; i++) begin
                        d = (store[i] > head) ? store[i] - head : head - store[i];
                        if (!used[i] && (best < 0 || d < bd)) begin
                            best = i; bd = d;
                        end
                    end
                    used[best] = 1;
                    visit(store[best]);
                end
            end else if (policy >= POL_SCAN && policy <= POL_CLOOK) begin
                circ = (policy == POL_CSCAN || policy == POL_CLOOK);
                sz = (dsize == 0) ? 1 : (dsize > 17'h10000) ? 32'h10000 : dsize;
                if (policy == POL_CSCAN || (policy == POL_SCAN && !down))
                    hi.push_back(CYL_W'(sz - 1));
                if (policy == POL_CSCAN || (policy == POL_SCAN && down))
                    lo.push_back('0);
                for (i = 0; i < cnt; i++)
                    if (store[i] > head0) hi.push_back(store[i]);
                    else lo.push_back(store[i]);
                lo.sort();
                hi.sort();
                if (down) begin
                    for (i = lo.size() - 1; i >= 0; i--) visit(lo[i]);
                    if (circ) for (i = hi.size() - 1; i >= 0; i--) visit(hi[i]);
                    else for (i = 0; i < hi.size(); i++) visit(hi[i]);
                end else begin
                    for (i = 0; i < hi.size(); i++) visit(hi[i]);
                    if (circ) for (i = 0; i < lo.size(); i++) visit(lo[i]);
                    else for (i = lo.size() - 1; i >= 0; i--) visit(lo[i]);
                end
            end else begin
                for (i = 0; i < cnt; i++) visit(store[i]);
            end
            if (pending.size() > nq) begin
                r = pending[$];
                r.last_result = 1'b1;
                pending[pending.size() - 1] = r;
            end
            cnt = 0;
        endfunction

        function void note_request(t_in it);
            if (cnt < MAXQ) begin
                store[cnt] = it.cylinder;
                cnt++;
            end
            if (it.last_request) schedule();
        endfunction

        function void check_result(t_out got);
            t_out w;
            if (pending.size() == 0) begin
                $error("unexpected result pos=%0d", got.served_position);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.served_position !== w.served_position) begin
                $error("served_position exp %0d got %0d", w.served_position,
                       got.served_position);
                errors++;
            end
            if (got.seek_total !== w.seek_total) begin
                $error("seek_total exp %0d got %0d", w.seek_total, got.seek_total);
                errors++;
            end
            if (got.last_result !== w.last_result) begin
                $error("last_result exp %0b got %0b", w.last_result, got.last_result);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_stall, o_out_valid, i_out_stall;
    t_in i_in;
    t_out o_out;
    logic psel, penable, pwrite, pready;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;

    seek_scoreboard sb;
    int src_idle, snk_idle;
    int idle_cycles;

    disk_seek_scheduler dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_request(i_in);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(99) < snk_idle);
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_POLICY: sb.policy = val[2:0];
            REG_HEAD:   sb.head0 = val[15:0];
            REG_SIZE:   sb.dsize = val[16:0];
            default:    sb.down = val[0];
        endcase
    endtask

    task automatic send(logic [CYL_W-1:0] cyl, logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_in.cylinder <= cyl;
        i_in.last_request <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic setup(logic [2:0] pol, logic [15:0] hd, logic [16:0] sz, bit dn);
        drain();
        reg_write(REG_POLICY, 32'(pol));
        reg_write(REG_HEAD, 32'(hd));
        reg_write(REG_SIZE, 32'(sz));
        reg_write(REG_DOWN, 32'(dn));
    endtask

    function automatic logic [15:0] rand_cyl(logic [16:0] sz);
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(15));
            default: return (sz > 1) ? 16'($urandom_range(32'(sz) - 1)) : 16'($urandom);
        endcase
    endfunction

    task automatic batch(int n, logic [16:0] sz);
        for (int i = 0; i < n; i++) send(rand_cyl(sz), i == n - 1);
    endtask

    initial begin
        logic [16:0] sz;
        sb = new();
        idle_cycles = 0;
        src_idle = 38; snk_idle = 62;
        i_rst_n = 0; i_in_valid = 0; i_in = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: FCFS extremes, then each policy on a fixed batch
        send(16'hFFFF, 0); send(16'd0, 0); send(16'h8000, 1);
        send(16'd5, 1);
        for (int p = 0; p < 8; p++) begin
            setup(p[2:0], 16'd50, 17'd200, p[0]);
            send(16'd50, 0); send(16'd10, 0); send(16'd90, 0); send(16'd199, 1);
        end
        setup(POL_SSTF, 16'd100, 17'd65536, 0);
        send(16'd90, 0); send(16'd110, 0); send(16'd100, 1);
        setup(POL_SCAN, 16'd0, 17'd0, 0);
        send(16'd0, 1);
        setup(POL_CSCAN, 16'hFFFF, 17'h1FFFF, 1);
        send(16'hFFFF, 1);
        // overfull store: requests past 32 are dropped, last still schedules
        setup(POL_FCFS, 16'd0, 17'd65536, 0);
        for (int i = 0; i < 35; i++) send(i[0] ? 16'hFFFF : 16'd0, i == 34);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 38 : (ph == 1) ? 62 : 0;
            snk_idle = (ph == 0) ? 62 : (ph == 1) ? 38 : 0;
            for (int b = 0; b < 7; b++) begin
                sz = ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(65536, 1));
                setup(3'($urandom_range(7)), 16'($urandom), sz, 1'($urandom_range(1)));
                batch(($urandom_range(9) == 0) ? 32 : $urandom_range(12, 1), sz);
            end
        end
        drain();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/dss_pkg.sv
src/dss_ctrl.sv
src/dss_datapath.sv
src/disk_seek_scheduler.sv
src/dss_checker.sv
verif/disk_seek_scheduler_tb.sv
